FILE: hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam int LIST_CAPACITY_DEF = 32;
    localparam int VALUE_W           = 32;
    localparam int COUNT_FIELD_W     = 6;

    typedef enum logic [1:0] {
        F_APPEND = 2'd0,
        F_INSERT = 2'd1,
        F_DELETE = 2'd2,
        F_DUMP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PLACE,
        S_DUMP,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_func                      func;
        logic signed [VALUE_W-1:0]  operand_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  element_value;
        t_status                    status;
        logic                       last;
        logic [COUNT_FIELD_W-1:0]   element_count;
    } t_out_word;

    // result handed from the controller to the output register
    typedef struct packed {
        logic       load;
        t_out_word  word;
    } t_res;

endpackage

`default_nettype wire

FILE: hw/rtl/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl
// List sequencer: search, shift, dump and report over the value store.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl #(
    parameter int LIST_CAPACITY = ole_pkg::LIST_CAPACITY_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire ole_pkg::t_in_word i_in_word,
    output logic                  o_busy,
    input  wire logic             i_out_free,
    output ole_pkg::t_res         o_res
);

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int VW = ole_pkg::VALUE_W;

    ole_pkg::t_state r_state, n_state;
    ole_pkg::t_func  r_func, n_func;
    ole_pkg::t_status r_status, n_status;
    logic signed [VW-1:0] r_value, n_value;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ri, n_ri;
    logic [CW-1:0] r_di, n_di;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_dv, n_dv;
    logic          r_more, n_more;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] last_idx, di_inc, di_dec, ri_inc, ri_dec, count_inc, count_dec;
    logic          full, empty, hit, dump_load, dump_issue;

    ole_ram #(
        .WIDTH (VW),
        .DEPTH (LIST_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign last_idx  = r_count - CW'(1);
    assign di_inc    = r_di + CW'(1);
    assign di_dec    = r_di - CW'(1);
    assign ri_inc    = r_ri + CW'(1);
    assign ri_dec    = r_ri - CW'(1);
    assign count_inc = r_count + CW'(1);
    assign count_dec = r_count - CW'(1);
    assign full      = (r_count == CW'(LIST_CAPACITY));
    assign empty     = (r_count == '0);

    // insert stops at the first element not below the value, delete at equality
    assign hit = r_dv && ((r_func == ole_pkg::F_INSERT) ?
                          !($signed(ram_rdata) < r_value) :
                          (ram_rdata == r_value));

    assign dump_load  = r_dv && i_out_free;
    assign dump_issue = r_more && (!r_dv || dump_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_status <= n_status;
        r_value  <= n_value;
        r_ri     <= n_ri;
        r_di     <= n_di;
        r_pos    <= n_pos;
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_status  = r_status;
        n_value   = r_value;
        n_count   = r_count;
        n_ri      = r_ri;
        n_di      = r_di;
        n_pos     = r_pos;
        n_dv      = r_dv;
        n_more    = r_more;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        o_res     = '0;
        o_busy    = 1'b1;

        unique case (r_state)
            ole_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    n_func  = i_in_word.func;
                    n_value = i_in_word.operand_value;
                    n_ri    = '0;
                    n_dv    = 1'b0;
                    n_more  = 1'b1;
                    unique case (i_in_word.func)
                        ole_pkg::F_APPEND, ole_pkg::F_INSERT: begin
                            if (full) begin
                                n_status = ole_pkg::ST_FULL;
                                n_state  = ole_pkg::S_REPORT;
                            end else if (i_in_word.func == ole_pkg::F_APPEND || empty) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_in_word.operand_value;
                                n_count   = count_inc;
                                n_status  = ole_pkg::ST_OK;
                                n_state   = ole_pkg::S_REPORT;
                            end else begin
                                n_state = ole_pkg::S_SEARCH;
                            end
                        end
                        ole_pkg::F_DELETE: begin
                            if (empty) begin
                                n_status = ole_pkg::ST_NOT_FOUND;
                                n_state  = ole_pkg::S_REPORT;
                            end else begin
                                n_state = ole_pkg::S_SEARCH;
                            end
                        end
                        ole_pkg::F_DUMP: begin
                            if (empty) begin
                                n_status = ole_pkg::ST_EMPTY;
                                n_state  = ole_pkg::S_REPORT;
                            end else begin
                                n_state = ole_pkg::S_DUMP;
                            end
                        end
                    endcase
                end
            end

            ole_pkg::S_SEARCH: begin
                if (hit) begin
                    n_pos  = r_di;
                    n_dv   = 1'b0;
                    n_more = 1'b1;
                    if (r_func == ole_pkg::F_INSERT) begin
                        n_ri    = last_idx;
                        n_state = ole_pkg::S_SHIFT_UP;
                    end else if (r_di == last_idx) begin
                        // tail match: nothing to close up
                        n_count  = count_dec;
                        n_status = ole_pkg::ST_OK;
                        n_state  = ole_pkg::S_REPORT;
                    end else begin
                        n_ri    = di_inc;
                        n_state = ole_pkg::S_SHIFT_DN;
                    end
                end else if (r_dv && r_di == last_idx) begin
                    if (r_func == ole_pkg::F_INSERT) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = r_value;
                        n_count   = count_inc;
                        n_status  = ole_pkg::ST_OK;
                    end else begin
                        n_status = ole_pkg::ST_NOT_FOUND;
                    end
                    n_state = ole_pkg::S_REPORT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ri[AW-1:0];
                    n_di      = r_ri;
                    n_ri      = ri_inc;
                    n_dv      = 1'b1;
                end
            end

            ole_pkg::S_SHIFT_UP: begin
                // read at a while writing a+2: the two never meet
                if (r_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ri[AW-1:0];
                    n_di      = r_ri;
                    n_dv      = 1'b1;
                    if (r_ri == r_pos) begin
                        n_more = 1'b0;
                    end else begin
                        n_ri = ri_dec;
                    end
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = di_inc[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (r_di == r_pos) begin
                        n_state = ole_pkg::S_PLACE;
                    end
                end
            end

            ole_pkg::S_SHIFT_DN: begin
                if (r_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ri[AW-1:0];
                    n_di      = r_ri;
                    n_dv      = 1'b1;
                    if (r_ri == last_idx) begin
                        n_more = 1'b0;
                    end else begin
                        n_ri = ri_inc;
                    end
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = di_dec[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (r_di == last_idx) begin
                        n_count  = count_dec;
                        n_status = ole_pkg::ST_OK;
                        n_state  = ole_pkg::S_REPORT;
                    end
                end
            end

            ole_pkg::S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_value;
                n_count   = count_inc;
                n_status  = ole_pkg::ST_OK;
                n_state   = ole_pkg::S_REPORT;
            end

            ole_pkg::S_DUMP: begin
                // read data holds in the ram while the output slot is busy
                if (dump_load) begin
                    o_res.load               = 1'b1;
                    o_res.word.element_value = ram_rdata;
                    o_res.word.status        = ole_pkg::ST_OK;
                    o_res.word.last          = (r_di == last_idx);
                    o_res.word.element_count = ole_pkg::COUNT_FIELD_W'(r_count);
                    if (r_di == last_idx) begin
                        n_state = ole_pkg::S_IDLE;
                    end
                end
                if (dump_issue) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ri[AW-1:0];
                    n_di      = r_ri;
                    n_dv      = 1'b1;
                    if (r_ri == last_idx) begin
                        n_more = 1'b0;
                    end else begin
                        n_ri = ri_inc;
                    end
                end else if (dump_load) begin
                    n_dv = 1'b0;
                end
            end

            ole_pkg::S_REPORT: begin
                if (i_out_free) begin
                    o_res.load               = 1'b1;
                    o_res.word.element_value = '0;
                    o_res.word.status        = r_status;
                    o_res.word.last          = 1'b1;
                    o_res.word.element_count = ole_pkg::COUNT_FIELD_W'(r_count);
                    n_state                  = ole_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_CAPACITY))
        else $error("element count above capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.load |-> i_out_free)
        else $error("result loaded into a busy output slot");

    a_dump_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_DUMP) |-> !ram_we)
        else $error("store written during dump");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same entry");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ole_pkg::S_IDLE && r_state != ole_pkg::S_SEARCH &&
         r_state != ole_pkg::S_SHIFT_DN && r_state != ole_pkg::S_PLACE)
        |=> $stable(r_count))
        else $error("count changed outside an update step");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed 32-bit values held in a single RAM.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one word: an operation and a
// value. Output channel o_out_valid / i_out_stall carries result words.
// Append, insert and delete give one result word; dump gives one word per
// element, head first, with last set on the tail (one empty word if none).
// Append and the full and empty-list cases go straight to the report step.
// Insert and delete walk the store element by element, a shift reading one
// entry as it writes another. Dump gives one word per cycle while the
// output is not held by a receiver stall.
// A new word is taken once the previous operation has left its last result
// in the output register, so the next item overlaps that delivery.
// While the receiver stalls the output word holds and the sequencer waits;
// a dump resumes without loss when the stall drops.
// Reset empties the list at once; the RAM content is never cleared, only
// entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_top #(
    parameter int LIST_CAPACITY = ole_pkg::LIST_CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire ole_pkg::t_in_word i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output ole_pkg::t_out_word     o_out_word,
    input  wire logic              i_out_stall
);

    logic               busy;
    logic               out_free;
    ole_pkg::t_res      res;
    logic               r_out_valid;
    ole_pkg::t_out_word r_out_word;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy;

    ole_ctrl #(
        .LIST_CAPACITY (LIST_CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_busy     (busy),
        .i_out_free (out_free),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_word <= res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: test/tb_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// Self-checking bench for the ordered list engine. A shadow list predicts
// every result word of append, ordered insert, delete and dump. The bench
// runs short directed cases, then random traffic under changing back-pressure.
// ----------------------------------------------------------------------------

module tb_ordered_list_engine_top;
    import ole_pkg::*;

    localparam int LIST_CAP    = LIST_CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;

    class ordered_list_scoreboard;
        int                        capacity;
        logic signed [VALUE_W-1:0] shadow_list[$];
        t_out_word                 expected_words[$];
        int unsigned               mismatch_count;

        function new(int cap);
            capacity       = cap;
            mismatch_count = 0;
        endfunction

        function void push_expected(logic signed [VALUE_W-1:0] value, t_status st, logic last);
            t_out_word w;
            w.element_value = value;
            w.status        = st;
            w.last          = last;
            w.element_count = COUNT_FIELD_W'(shadow_list.size());
            expected_words.push_back(w);
        endfunction

        // apply one accepted operation to the shadow list, queue its results
        function void note_operation(t_in_word w);
            t_status                   st;
            int                        pos;
            logic signed [VALUE_W-1:0] v;
            v   = w.operand_value;
            st  = ST_OK;
            pos = 0;
            case (w.func)
                F_APPEND: begin
                    if (shadow_list.size() >= capacity) begin
                        st = ST_FULL;
                    end else begin
                        shadow_list.push_back(v);
                    end
                end
                F_INSERT: begin
                    if (shadow_list.size() >= capacity) begin
                        st = ST_FULL;
                    end else begin
                        while (pos < shadow_list.size() && shadow_list[pos] < v) begin
                            pos++;
                        end
                        shadow_list.insert(pos, v);
                    end
                end
                F_DELETE: begin
                    while (pos < shadow_list.size() && shadow_list[pos] != v) begin
                        pos++;
                    end
                    if (pos >= shadow_list.size()) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        shadow_list.delete(pos);
                    end
                end
                default: begin
                    if (shadow_list.size() == 0) begin
                        push_expected('0, ST_EMPTY, 1'b1);
                    end else begin
                        foreach (shadow_list[i]) begin
                            push_expected(shadow_list[i], ST_OK, i == shadow_list.size() - 1);
                        end
                    end
                    return;
                end
            endcase
            push_expected('0, st, 1'b1);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: element_value %0d status %0d last %0d count %0d",
                       got.element_value, got.status, got.last, got.element_count);
                mismatch_count++;
                return;
            end
            want = expected_words.pop_front();
            if (got.element_value !== want.element_value) begin
                $error("element_value: expected %0d, got %0d",
                       want.element_value, got.element_value);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
            if (got.element_count !== want.element_count) begin
                $error("element_count: expected %0d, got %0d",
                       want.element_count, got.element_count);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall = 1'b0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned cycle_count    = 0;
    bit          growing        = 1'b1;
    int          full_hits      = 0;

    ordered_list_scoreboard list_sb = new(LIST_CAP);

    ordered_list_engine_top #(
        .LIST_CAPACITY(LIST_CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall, or a counted hold-off when one is requested
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // both channels sampled at the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                list_sb.check_word(o_out_word);
            end
            if (i_in_valid && !o_in_stall) begin
                list_sb.note_operation(i_in_word);
            end
        end
    end

    task automatic send_word(t_func f, logic signed [VALUE_W-1:0] v);
        t_in_word w;
        w.func          = f;
        w.operand_value = v;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (list_sb.pending() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value(bit from_list);
        int sel;
        int n;
        sel = $urandom_range(9);
        n   = list_sb.shadow_list.size();
        if (from_list && n != 0) begin
            return list_sb.shadow_list[$urandom_range(n - 1)];
        end
        if (sel < 5) begin
            return $urandom;
        end
        // narrow pool so duplicates and equal compares show up
        if (sel < 8) begin
            return int'($urandom_range(6)) - 3;
        end
        case ($urandom_range(3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // fill toward full, bounce off it a few times, then drain back to empty
    task automatic run_random(int count, int unsigned hold_len);
        int    n;
        int    roll;
        t_func f;
        bit    from_list;
        for (n = 0; n < count; n++) begin
            if (list_sb.shadow_list.size() >= LIST_CAP) begin
                full_hits++;
                if (full_hits >= 4) begin
                    growing = 1'b0;
                end
            end else if (list_sb.shadow_list.size() == 0) begin
                growing   = 1'b1;
                full_hits = 0;
            end
            roll = $urandom_range(99);
            if (roll < 10) begin
                f = F_DUMP;
            end else if (growing) begin
                f = (roll < 18) ? F_DELETE : ((roll < 59) ? F_APPEND : F_INSERT);
            end else begin
                f = (roll < 80) ? F_DELETE : ((roll < 90) ? F_APPEND : F_INSERT);
            end
            if (f == F_DELETE) begin
                from_list = ($urandom_range(3) != 0);
            end else begin
                from_list = ($urandom_range(7) == 0);
            end
            send_word(f, random_value(from_list));
            if (n == count / 3 && hold_len != 0) begin
                hold_request = hold_len;
            end
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 20;
        recv_stall_pct = 82;

        send_word(F_DUMP,   0);
        send_word(F_DELETE, 5);
        send_word(F_APPEND, 32'sh7FFF_FFFF);
        send_word(F_APPEND, 32'sh8000_0000);
        send_word(F_INSERT, 0);
        send_word(F_INSERT, 0);
        send_word(F_INSERT, -1);
        send_word(F_APPEND, -1);
        send_word(F_DUMP,   32'sh5A5A_5A5A);
        send_word(F_DELETE, -1);
        send_word(F_DELETE, 12345);
        send_word(F_DELETE, 32'sh8000_0000);
        send_word(F_INSERT, 32'sh8000_0000);
        send_word(F_INSERT, 32'sh7FFF_FFFF);
        send_word(F_DUMP,   -1);
        send_word(F_DELETE, 0);
        send_word(F_DELETE, 0);
        send_word(F_DELETE, 32'sh7FFF_FFFF);
        send_word(F_DELETE, 32'sh7FFF_FFFF);
        send_word(F_DUMP,   32'shA5A5_A5A5);
        wait_drained();

        run_random(117, 300);
        wait_drained();

        send_idle_pct  = 82;
        recv_stall_pct = 20;
        run_random(117, 200);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(116, 0);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (list_sb.mismatch_count == 0 && list_sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
